[rtl/core/wchd_pkg.sv]
// Shared types, constants and functions for the word chain hash and distance check.
`timescale 1ns / 1ps
package wchd_pkg;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int HASH_W  = 64;
    localparam int DIST_W  = 6;
    localparam int CNT_W   = 32;
    localparam int PC_W    = 4;
    localparam int STEP_W  = 2;

    localparam logic [HASH_W-1:0] FNV_BASIS     = 64'hcbf2_9ce4_8422_2325;
    localparam logic [HASH_W-1:0] FNV_PRIME_LOW = 64'h0000_0000_0000_01b3;
    localparam int                FNV_PRIME_SH  = 40;
    localparam logic [CNT_W-1:0]  COUNT_MAX     = 32'hffff_ffff;
    localparam logic [DIST_W-1:0] LIMIT_RESET   = 6'd32;
    localparam logic [STEP_W-1:0] LAST_STEP     = 2'd3;

    typedef struct packed {
        logic step;
        logic final_step;
        logic clear;
    } t_ctrl;

    function automatic logic [PC_W-1:0] f_popcnt8(input logic [BYTE_W-1:0] v);
        logic [PC_W-1:0] s;
        s = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            s = s + {{(PC_W-1){1'b0}}, v[i]};
        end
        return s;
    endfunction

endpackage

[rtl/core/wchd_hash_unit.sv]
// Byte-serial FNV-1a 64-bit hash accumulator.
`timescale 1ns / 1ps
module wchd_hash_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wchd_pkg::t_ctrl               i_ctrl,
    input  logic [wchd_pkg::BYTE_W-1:0]   i_byte,
    output logic [wchd_pkg::HASH_W-1:0]   o_next_hash
);
    import wchd_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] w_mix;

    always_comb begin
        w_mix  = r_hash ^ {{(HASH_W-BYTE_W){1'b0}}, i_byte};
        n_hash = (w_mix * FNV_PRIME_LOW) + (w_mix << FNV_PRIME_SH);
    end

    assign o_next_hash = n_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= FNV_BASIS;
        end else if (i_ctrl.step) begin
            if (i_ctrl.clear) begin
                r_hash <= FNV_BASIS;
            end else begin
                r_hash <= n_hash;
            end
        end
    end

endmodule

[rtl/core/wchd_dist_unit.sv]
// Byte-serial Hamming distance between neighbor words, with maximum and violation count.
`timescale 1ns / 1ps
module wchd_dist_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wchd_pkg::t_ctrl               i_ctrl,
    input  logic [wchd_pkg::BYTE_W-1:0]   i_byte,
    input  logic [wchd_pkg::DIST_W-1:0]   i_limit,
    output logic [wchd_pkg::DIST_W-1:0]   o_next_max,
    output logic [wchd_pkg::CNT_W-1:0]    o_next_count
);
    import wchd_pkg::*;

    logic [WORD_W-1:0] r_prev;
    logic              r_have;
    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_max;
    logic [CNT_W-1:0]  r_count;

    logic [DIST_W-1:0] n_sum;
    logic [DIST_W-1:0] n_max;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        n_sum   = r_sum + {{(DIST_W-PC_W){1'b0}}, f_popcnt8(r_prev[BYTE_W-1:0] ^ i_byte)};
        n_max   = r_max;
        n_count = r_count;
        if (r_have) begin
            if (n_sum > r_max) begin
                n_max = n_sum;
            end
            if ((n_sum > i_limit) && (r_count != COUNT_MAX)) begin
                n_count = r_count + 32'd1;
            end
        end
    end

    assign o_next_max   = n_max;
    assign o_next_count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_have  <= 1'b0;
            r_sum   <= '0;
            r_max   <= '0;
            r_count <= '0;
        end else if (i_ctrl.step) begin
            if (i_ctrl.clear) begin
                r_prev  <= '0;
                r_have  <= 1'b0;
                r_sum   <= '0;
                r_max   <= '0;
                r_count <= '0;
            end else begin
                r_prev <= {i_byte, r_prev[WORD_W-1:BYTE_W]};
                if (i_ctrl.final_step) begin
                    r_have  <= 1'b1;
                    r_sum   <= '0;
                    r_max   <= n_max;
                    r_count <= n_count;
                end else begin
                    r_sum <= n_sum;
                end
            end
        end
    end

endmodule

[rtl/core/word_chain_hash_and_distance_check.sv]
// Top level: word sequencer, configuration register and result register.
// Each word is handled in 4 byte steps; the result register loads on the last step
// of the final word of a sequence.
// A new item is taken in the last byte step of the current one.
// Reset (synchronous, active low) restores the offset basis, clears the chain
// and sets the distance limit to 32.
`timescale 1ns / 1ps
module word_chain_hash_and_distance_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wchd_pkg::DIST_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [wchd_pkg::WORD_W-1:0]   i_data_word,
    input  logic                          i_end_of_sequence,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [wchd_pkg::HASH_W-1:0]   o_hash_value,
    output logic [wchd_pkg::DIST_W-1:0]   o_largest_distance,
    output logic [wchd_pkg::CNT_W-1:0]    o_violation_count,
    output logic                          o_passed
);
    import wchd_pkg::*;

    logic [DIST_W-1:0] r_limit;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [WORD_W-1:0] r_word;
    logic              r_last;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_hash_o;
    logic [DIST_W-1:0] r_dist_o;
    logic [CNT_W-1:0]  r_cnt_o;

    t_ctrl             w_ctrl;
    logic              w_accept;
    logic [HASH_W-1:0] w_next_hash;
    logic [DIST_W-1:0] w_next_max;
    logic [CNT_W-1:0]  w_next_count;

    always_comb begin
        w_ctrl.step       = r_busy &
                            ~((r_step == LAST_STEP) & r_last & r_out_valid & i_out_stall);
        w_ctrl.final_step = w_ctrl.step & (r_step == LAST_STEP);
        w_ctrl.clear      = w_ctrl.final_step & r_last;
    end

    assign o_in_stall = r_busy & ~w_ctrl.final_step;
    assign w_accept   = i_in_valid & ~o_in_stall;

    wchd_hash_unit u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_byte      (r_word[BYTE_W-1:0]),
        .o_next_hash (w_next_hash)
    );

    wchd_dist_unit u_dist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_byte       (r_word[BYTE_W-1:0]),
        .i_limit      (r_limit),
        .o_next_max   (w_next_max),
        .o_next_count (w_next_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (w_ctrl.final_step) begin
            r_busy <= 1'b0;
        end else if (w_ctrl.step) begin
            r_step <= r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_data_word;
            r_last <= i_end_of_sequence;
        end else if (w_ctrl.step) begin
            r_word <= {{BYTE_W{1'b0}}, r_word[WORD_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.clear) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.clear) begin
            r_hash_o <= w_next_hash;
            r_dist_o <= w_next_max;
            r_cnt_o  <= w_next_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_hash_value       = r_hash_o;
    assign o_largest_distance = r_dist_o;
    assign o_violation_count  = r_cnt_o;
    assign o_passed           = (r_cnt_o == '0);

endmodule

[sim/tb.sv]
// Self-checking testbench for the word chain hash and distance check block.
`timescale 1ns / 1ps
module tb;
    import wchd_pkg::*;

    localparam int        CLK_HALF    = 10;
    localparam int        RESET_CYC   = 6;
    localparam int        SETTLE_CYC  = 12;
    localparam int        CYCLE_LIMIT = 400000;
    localparam int        RAND_ITEMS  = 530;
    localparam int        CALM_ITEMS  = 450;
    localparam int        HOLD_CYC    = 300;
    localparam logic [63:0] HASH_SEED  = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_MULT  = 64'h00000100000001b3;
    localparam logic [31:0] TALLY_TOP  = 32'hffffffff;
    localparam int        NUM_ROWS    = 18;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [DIST_W-1:0] peak;
        logic [CNT_W-1:0]  tally;
        logic              ok;
    } t_digest;

    typedef struct packed {
        logic              cfg_en;
        logic [DIST_W-1:0] cfg_val;
        logic [WORD_W-1:0] word;
        logic              eos;
        logic              known;
        logic [DIST_W-1:0] k_peak;
        logic [CNT_W-1:0]  k_tally;
        logic              k_ok;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [DIST_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [WORD_W-1:0] i_data_word = '0;
    logic              i_end_of_sequence = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [HASH_W-1:0] o_hash_value;
    logic [DIST_W-1:0] o_largest_distance;
    logic [CNT_W-1:0]  o_violation_count;
    logic              o_passed;

    logic [HASH_W-1:0] chain_hash;
    logic [WORD_W-1:0] last_word;
    logic              have_last;
    logic [DIST_W-1:0] peak_distance;
    logic [CNT_W-1:0]  over_limit_count;
    logic [DIST_W-1:0] limit_reg;

    t_digest pending_digests[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;
    bit      long_hold_req = 1'b0;
    bit      long_hold_done = 1'b0;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{1'b0, 6'd0,  32'h00000000, 1'b1, 1'b1, 6'd0,  32'd0, 1'b1},
        '{1'b0, 6'd0,  32'hffffffff, 1'b1, 1'b1, 6'd0,  32'd0, 1'b1},
        '{1'b0, 6'd0,  32'h00000000, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'hffffffff, 1'b1, 1'b1, 6'd32, 32'd0, 1'b1},
        '{1'b1, 6'd0,  32'ha5a5a5a5, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'ha5a5a5a5, 1'b1, 1'b1, 6'd0,  32'd0, 1'b1},
        '{1'b0, 6'd0,  32'h00000000, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'h00000001, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'h00000003, 1'b1, 1'b1, 6'd1,  32'd2, 1'b0},
        '{1'b1, 6'd31, 32'h00000000, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'hffffffff, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'h00000000, 1'b1, 1'b1, 6'd32, 32'd2, 1'b0},
        '{1'b1, 6'd63, 32'h00000000, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'hffffffff, 1'b1, 1'b1, 6'd32, 32'd0, 1'b1},
        '{1'b1, 6'd32, 32'h12345678, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'h9abcdef0, 1'b0, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'h80000001, 1'b1, 1'b0, 6'd0,  32'd0, 1'b0},
        '{1'b0, 6'd0,  32'hdeadbeef, 1'b1, 1'b0, 6'd0,  32'd0, 1'b0}
    };

    word_chain_hash_and_distance_check uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_data_word        (i_data_word),
        .i_end_of_sequence  (i_end_of_sequence),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_hash_value       (o_hash_value),
        .o_largest_distance (o_largest_distance),
        .o_violation_count  (o_violation_count),
        .o_passed           (o_passed)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    function automatic void clear_chain();
        chain_hash       = HASH_SEED;
        last_word        = '0;
        have_last        = 1'b0;
        peak_distance    = '0;
        over_limit_count = '0;
    endfunction

    function automatic bit fold_word(input logic [WORD_W-1:0] w, input logic eos,
                                     output t_digest d);
        int pair_dist;
        for (int k = 0; k < 4; k++) begin
            chain_hash = (chain_hash ^ {56'd0, w[8*k +: 8]}) * HASH_MULT;
        end
        if (have_last) begin
            pair_dist = $countones(last_word ^ w);
            if (pair_dist > peak_distance)
                peak_distance = pair_dist[DIST_W-1:0];
            if (pair_dist > limit_reg && over_limit_count != TALLY_TOP)
                over_limit_count = over_limit_count + 1;
        end
        last_word = w;
        have_last = 1'b1;
        d = '0;
        if (!eos)
            return 1'b0;
        d.hash  = chain_hash;
        d.peak  = peak_distance;
        d.tally = over_limit_count;
        d.ok    = (over_limit_count == 0);
        clear_chain();
        return 1'b1;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic eos,
                             output bit has_digest, output t_digest d);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_data_word       <= w;
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (o_in_stall);
        has_digest = fold_word(w, eos, d);
    endtask

    task automatic set_limit(input logic [DIST_W-1:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_digests.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        limit_reg  = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [DIST_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'd63;
            default: return DIST_W'($urandom_range(0, 32));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] prev);
        logic [WORD_W-1:0] mask;
        int flips;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return $urandom;
            default: begin
                mask  = '0;
                flips = $urandom_range(0, 32);
                repeat (flips) mask[$urandom_range(0, WORD_W-1)] = 1'b1;
                return prev ^ mask;
            end
        endcase
    endfunction

    initial begin
        t_digest d;
        bit      has_d;
        int      sent;
        int      seq_len;
        int      seq_count;
        logic [WORD_W-1:0] w;

        limit_reg = LIMIT_RESET;
        clear_chain();
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_en)
                set_limit(directed_rows[r].cfg_val);
            send_word(directed_rows[r].word, directed_rows[r].eos, has_d, d);
            if (has_d) begin
                if (directed_rows[r].known) begin
                    d.peak  = directed_rows[r].k_peak;
                    d.tally = directed_rows[r].k_tally;
                    d.ok    = directed_rows[r].k_ok;
                end
                pending_digests.push_back(d);
            end
        end

        sent      = 0;
        seq_count = 0;
        w         = $urandom;
        while (sent < RAND_ITEMS) begin
            if (seq_count % 15 == 14)
                set_limit(pick_limit());
            if (seq_count == 8)
                long_hold_req = 1'b1;
            seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                   : $urandom_range(1, 6);
            for (int k = 0; k < seq_len; k++) begin
                w = next_word(w);
                send_word(w, k == seq_len - 1, has_d, d);
                if (has_d)
                    pending_digests.push_back(d);
                sent++;
                if (sent >= CALM_ITEMS)
                    calm = 1'b1;
            end
            seq_count++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("word_chain_hash_and_distance_check: match");
        else
            $display("word_chain_hash_and_distance_check: mismatch");
        $finish;
    end

    initial begin
        int burst;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYC) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_digest e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_digests.size() == 0) begin
                $error("unexpected result: hash_value %h", o_hash_value);
                mismatch_count++;
            end else begin
                e = pending_digests.pop_front();
                if (o_hash_value !== e.hash) begin
                    $error("hash_value: expected %h, actual %h", e.hash, o_hash_value);
                    mismatch_count++;
                end
                if (o_largest_distance !== e.peak) begin
                    $error("largest_distance: expected %0d, actual %0d",
                           e.peak, o_largest_distance);
                    mismatch_count++;
                end
                if (o_violation_count !== e.tally) begin
                    $error("violation_count: expected %0d, actual %0d",
                           e.tally, o_violation_count);
                    mismatch_count++;
                end
                if (o_passed !== e.ok) begin
                    $error("passed: expected %0d, actual %0d", e.ok, o_passed);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("word_chain_hash_and_distance_check: mismatch");
        $finish;
    end

endmodule

[word_chain_hash_and_distance_check.f]
rtl/core/wchd_pkg.sv
rtl/core/wchd_hash_unit.sv
rtl/core/wchd_dist_unit.sv
rtl/core/word_chain_hash_and_distance_check.sv
sim/tb.sv
